// ===== rtl/hbp_pkg.sv =====
// Package for the Huffman bit packer: item kinds, field widths and the command
// record passed from the front end through the queue to the back end.
// No dependencies.
package hbp_pkg;

    localparam int SYM_W        = 8;
    localparam int LEN_W        = 6;
    localparam int CODE_W       = 48;
    localparam int WORD_W       = 16;
    localparam int KIND_W       = 2;
    localparam int ENTRY_W      = LEN_W + CODE_W;
    localparam int TABLE_DEPTH  = 256;
    localparam int S_TDATA_W    = 64;

    localparam int MAX_CODE_LEN_DEF = 48;
    localparam int QUEUE_DEPTH_DEF  = 4;

    // Input tdata field positions.
    localparam int SYM_LSB  = 0;
    localparam int LEN_LSB  = SYM_LSB + SYM_W;
    localparam int CODE_LSB = LEN_LSB + LEN_W;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD = 2'd0,
        KIND_DATA = 2'd1,
        KIND_END  = 2'd2,
        KIND_NONE = 2'd3
    } t_kind;

    // One queued command: a flush, or a code left-justified in bits.
    typedef struct packed {
        logic              is_end;
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] bits;
    } t_cmd;

endpackage

// ===== rtl/hbp_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module hbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/hbp_front.sv =====
// Front end of the bit packer: accepts input transactions, writes table loads
// into the code store and turns data bytes and flushes into queued commands.
// Depends on hbp_pkg and hbp_ram.
module hbp_front #(
    parameter int MAX_CODE_LEN = hbp_pkg::MAX_CODE_LEN_DEF,
    parameter int QUEUE_DEPTH  = hbp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [hbp_pkg::S_TDATA_W-1:0]       i_s_axis_tdata,
    input  logic [hbp_pkg::KIND_W-1:0]          i_s_axis_tuser,
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0]    i_q_level,
    output logic                                o_push,
    output hbp_pkg::t_cmd                       o_cmd
);
    import hbp_pkg::*;

    localparam int LVL_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W = $clog2(TABLE_DEPTH);

    logic               accept;
    t_kind              kind;
    logic [SYM_W-1:0]   sym;
    logic [LEN_W-1:0]   len_in;
    logic [LEN_W-1:0]   len_clamped;
    logic [CODE_W-1:0]  code_in;
    logic [CODE_W-1:0]  code_mask;
    logic [ENTRY_W-1:0] wr_entry;
    logic [ENTRY_W-1:0] rd_entry;
    logic [LEN_W-1:0]   rd_len;
    logic [LEN_W-1:0]   justify_shift;
    logic [LVL_W:0]     pending;
    logic               r_s1_valid;
    logic               r_s1_end;

    assign kind    = t_kind'(i_s_axis_tuser);
    assign sym     = i_s_axis_tdata[SYM_LSB +: SYM_W];
    assign len_in  = i_s_axis_tdata[LEN_LSB +: LEN_W];
    assign code_in = i_s_axis_tdata[CODE_LSB +: CODE_W];

    // Room is reserved for the command still in the read stage.
    assign pending         = {1'b0, i_q_level} + (LVL_W + 1)'(r_s1_valid);
    assign o_s_axis_tready = pending < (LVL_W + 1)'(QUEUE_DEPTH);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    assign len_clamped = (len_in > LEN_W'(MAX_CODE_LEN)) ? LEN_W'(MAX_CODE_LEN) : len_in;
    assign code_mask   = ~({CODE_W{1'b1}} << len_clamped);
    assign wr_entry    = {len_clamped, code_in & code_mask};

    hbp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_code_store (
        .i_clk   (i_clk),
        .i_we    (accept && (kind == KIND_LOAD)),
        .i_waddr (ADDR_W'(sym)),
        .i_wdata (wr_entry),
        .i_re    (accept && (kind == KIND_DATA)),
        .i_raddr (ADDR_W'(sym)),
        .o_rdata (rd_entry)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept && ((kind == KIND_DATA) || (kind == KIND_END));
        end
        if (accept) begin
            r_s1_end <= (kind == KIND_END);
        end
    end

    // The back end consumes codes from the top bit down, so justify them left.
    assign rd_len        = rd_entry[CODE_W +: LEN_W];
    assign justify_shift = LEN_W'(CODE_W) - rd_len;

    assign o_push      = r_s1_valid;
    assign o_cmd.is_end = r_s1_end;
    assign o_cmd.len    = rd_len;
    assign o_cmd.bits   = rd_entry[CODE_W-1:0] << justify_shift;

endmodule

// ===== rtl/hbp_queue.sv =====
// Short command queue between the front end and the back end of the packer.
// Depends on hbp_pkg.
module hbp_queue #(
    parameter int DEPTH = hbp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  hbp_pkg::t_cmd                 i_cmd,
    input  logic                          i_pop,
    output logic                          o_valid,
    output hbp_pkg::t_cmd                 o_cmd,
    output logic [$clog2(DEPTH+1)-1:0]    o_level
);
    import hbp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LVL_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [LVL_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;

    assign n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign o_level = r_count;

endmodule

// ===== rtl/hbp_back.sv =====
// Back end of the packer: merges queued codes into the 16-bit accumulator,
// emits each completed word and the flush word through an output register.
// Depends on hbp_pkg.
module hbp_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_q_valid,
    input  hbp_pkg::t_cmd              i_cmd,
    output logic                       o_pop,
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    output logic [hbp_pkg::WORD_W-1:0] o_m_axis_tdata,
    output logic                       o_m_axis_tlast,
    output logic [0:0]                 o_m_axis_tuser
);
    import hbp_pkg::*;

    localparam int OFF_W = $clog2(WORD_W);
    localparam int SUM_W = LEN_W + 1;

    // Pending bits sit left-justified in r_acc; r_off counts them.
    logic [WORD_W-1:0] r_acc;
    logic [OFF_W-1:0]  r_off;
    logic              r_busy;
    logic [LEN_W-1:0]  r_rem;
    logic [CODE_W-1:0] r_bits;
    logic              r_out_valid;
    logic [WORD_W-1:0] r_word;
    logic              r_last;
    logic              r_has;

    logic [WORD_W-1:0] n_acc;
    logic [OFF_W-1:0]  n_off;
    logic              n_busy;
    logic [LEN_W-1:0]  n_rem;
    logic [CODE_W-1:0] n_bits;
    logic              emit;
    logic [WORD_W-1:0] emit_word;
    logic              emit_last;
    logic              emit_has;

    logic              have;
    logic              cur_end;
    logic [LEN_W-1:0]  cur_rem;
    logic [CODE_W-1:0] cur_bits;
    logic [SUM_W-1:0]  sum;
    logic              fills;
    logic              out_free;
    logic              step;
    logic [OFF_W:0]    need;
    logic [WORD_W-1:0] top;
    logic [LEN_W-1:0]  rem_after;

    assign have     = r_busy || i_q_valid;
    assign cur_end  = !r_busy && i_cmd.is_end;
    assign cur_rem  = r_busy ? r_rem : i_cmd.len;
    assign cur_bits = r_busy ? r_bits : i_cmd.bits;
    assign sum      = SUM_W'(r_off) + SUM_W'(cur_rem);
    assign fills    = sum >= SUM_W'(WORD_W);
    assign out_free = !r_out_valid || i_m_axis_tready;
    assign step     = have && (!(cur_end || fills) || out_free);
    assign need     = (OFF_W + 1)'(WORD_W) - (OFF_W + 1)'(r_off);
    assign top      = cur_bits[CODE_W-1 -: WORD_W] >> r_off;
    assign rem_after = cur_rem - LEN_W'(need);
    assign o_pop    = step && !r_busy;

    always_comb begin
        n_acc     = r_acc;
        n_off     = r_off;
        n_busy    = r_busy;
        n_rem     = r_rem;
        n_bits    = r_bits;
        emit      = 1'b0;
        emit_word = r_acc;
        emit_last = 1'b0;
        emit_has  = 1'b1;
        if (step) begin
            priority if (cur_end) begin
                emit      = 1'b1;
                emit_last = 1'b1;
                emit_has  = (r_off != '0);
                n_acc     = '0;
                n_off     = '0;
                n_busy    = 1'b0;
            end else if (fills) begin
                emit      = 1'b1;
                emit_word = r_acc | top;
                n_acc     = '0;
                n_off     = '0;
                n_bits    = cur_bits << need;
                n_rem     = rem_after;
                n_busy    = (rem_after != '0);
            end else begin
                n_acc  = r_acc | top;
                n_off  = r_off + OFF_W'(cur_rem);
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_off       <= '0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_acc  <= n_acc;
            r_off  <= n_off;
            r_busy <= n_busy;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        r_rem  <= n_rem;
        r_bits <= n_bits;
        if (emit) begin
            r_word <= emit_word;
            r_last <= emit_last;
            r_has  <= emit_has;
        end
    end

    assign o_m_axis_tvalid   = r_out_valid;
    assign o_m_axis_tdata    = r_word;
    assign o_m_axis_tlast    = r_last;
    assign o_m_axis_tuser[0] = r_has;

endmodule

// ===== rtl/huffman_bit_packer.sv =====
// Huffman bit packer: front end with the 256-entry code store, command queue
// and word-assembly back end. Depends on hbp_pkg, hbp_front, hbp_queue, hbp_back.
// Path: code store read register, queue, back-end merge, output register.
// Throughput: one item per cycle while no word completes and the queue has room; an item
// that completes words emits them one at a time and waits while the output is stalled.
// Reset: synchronous, active low; clears the accumulator, queue and handshakes.
module huffman_bit_packer #(
    parameter int MAX_CODE_LEN = hbp_pkg::MAX_CODE_LEN_DEF,
    parameter int QUEUE_DEPTH  = hbp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // symbol[7:0], code_length[13:8], code_bits[61:14], zeros[63:62]
    input  logic [hbp_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    // kind[1:0]
    input  logic [hbp_pkg::KIND_W-1:0]    i_s_axis_tuser,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // packed_word[15:0]
    output logic [hbp_pkg::WORD_W-1:0]    o_m_axis_tdata,
    output logic                          o_m_axis_tlast,
    // has_data[0]
    output logic [0:0]                    o_m_axis_tuser
);
    import hbp_pkg::*;

    localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

    logic             push;
    t_cmd             push_cmd;
    logic             pop;
    logic             q_valid;
    t_cmd             q_cmd;
    logic [LVL_W-1:0] q_level;

    hbp_front #(
        .MAX_CODE_LEN (MAX_CODE_LEN),
        .QUEUE_DEPTH  (QUEUE_DEPTH)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_q_level       (q_level),
        .o_push          (push),
        .o_cmd           (push_cmd)
    );

    hbp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .o_level (q_level)
    );

    hbp_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_cmd           (q_cmd),
        .o_pop           (pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

endmodule

// ===== rtl/hbp_checker.sv =====
// Port-level checks for the Huffman bit packer, attached by bind.
// Depends on hbp_pkg.
module hbp_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_m_axis_tvalid,
    input logic                          i_m_axis_tready,
    input logic [hbp_pkg::WORD_W-1:0]    o_m_axis_tdata,
    input logic                          o_m_axis_tlast,
    input logic [0:0]                    o_m_axis_tuser
);
    import hbp_pkg::*;

    // No result may be shown in the cycle after a reset.
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    // A stalled result holds its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast)
            && $stable(o_m_axis_tuser))
        else $error("stalled output transaction changed");

    // An empty result can only be a flush, and it carries a zero word.
    a_empty_is_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser[0] |-> o_m_axis_tlast && (o_m_axis_tdata == '0))
        else $error("empty result that is not a zero flush");

    // Every completed data word carries bits.
    a_data_has_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tlast |-> o_m_axis_tuser[0])
        else $error("data word marked empty");

endmodule

bind huffman_bit_packer hbp_checker u_hbp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for huffman_bit_packer: loads code tables, streams bytes and flushes,
// and predicts every packed output word. Depends on hbp_pkg and the huffman_bit_packer RTL.
module tb_top;
    import hbp_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int RST_CYCLES    = 12;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 20;
    localparam int MAX_REPORTS   = 10;
    localparam int MAX_LEN       = MAX_CODE_LEN_DEF;

    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] bits;
    } t_code;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              last;
        logic              has_data;
    } t_word;

    logic                 clk;
    logic                 rst_n  = 1'b0;
    logic                 s_valid = 1'b0;
    logic [S_TDATA_W-1:0] s_data = '0;
    logic [KIND_W-1:0]    s_user = KIND_NONE;
    logic                 m_ready = 1'b0;
    logic                 s_ready;
    logic                 m_valid;
    logic [WORD_W-1:0]    m_data;
    logic                 m_last;
    logic [0:0]           m_user;

    // Shadow copy of the code store and the word accumulator.
    t_code             code_store [TABLE_DEPTH];
    bit                loaded [TABLE_DEPTH];
    logic [SYM_W-1:0]  loaded_syms [$];
    int                pend_count = 0;
    logic [WORD_W-1:0] pend_bits = '0;
    t_word             expected_words [$];

    int mismatches    = 0;
    int idle_cycles   = 0;
    int src_idle_pct  = 19;
    int sink_idle_pct = 71;

    huffman_bit_packer dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tlast  (m_last),
        .o_m_axis_tuser  (m_user)
    );

    initial begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    always @(posedge clk) begin
        m_ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Works out the words that one accepted transaction produces.
    task automatic pack_codes(input t_kind kind, input logic [SYM_W-1:0] sym,
                              input logic [LEN_W-1:0] len, input logic [CODE_W-1:0] bits);
        t_code       entry;
        logic [63:0] mask;
        int          i;
        case (kind)
            KIND_LOAD: begin
                entry.len  = (len > MAX_LEN) ? LEN_W'(MAX_LEN) : len;
                mask       = (64'd1 << entry.len) - 64'd1;
                entry.bits = bits & mask[CODE_W-1:0];
                code_store[sym] = entry;
                if (!loaded[sym]) begin
                    loaded[sym] = 1'b1;
                    loaded_syms.push_back(sym);
                end
            end
            KIND_DATA: begin
                entry = code_store[sym];
                for (i = entry.len; i > 0; i--) begin
                    pend_bits = {pend_bits[WORD_W-2:0], entry.bits[i-1]};
                    pend_count++;
                    if (pend_count == WORD_W) begin
                        expected_words.push_back('{pend_bits, 1'b0, 1'b1});
                        pend_bits  = '0;
                        pend_count = 0;
                    end
                end
            end
            KIND_END: begin
                if (pend_count != 0)
                    expected_words.push_back('{WORD_W'(pend_bits << (WORD_W - pend_count)),
                                              1'b1, 1'b1});
                else
                    expected_words.push_back('{'0, 1'b1, 1'b0});
                pend_bits  = '0;
                pend_count = 0;
            end
            default: ;
        endcase
    endtask

    // Valid is left high after a transaction; the next call either idles or presents new data.
    task automatic send_item(input t_kind kind, input logic [SYM_W-1:0] sym,
                             input logic [LEN_W-1:0] len, input logic [CODE_W-1:0] bits);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= {2'b00, bits, len, sym};
        s_user  <= kind;
        @(posedge clk);
        while (!s_ready) @(posedge clk);
        pack_codes(kind, sym, len, bits);
    endtask

    task automatic send_byte(input logic [SYM_W-1:0] sym);
        send_item(KIND_DATA, sym, LEN_W'($urandom), {$urandom, $urandom});
    endtask

    task automatic send_flush();
        send_item(KIND_END, SYM_W'($urandom), LEN_W'($urandom), {$urandom, $urandom});
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic test_directed_cases();
        send_item(KIND_LOAD, 8'h00, 6'd48, 48'hFFFF_FFFF_FFFF);
        // Only the low bit of the code survives a one-bit load.
        send_item(KIND_LOAD, 8'hFF, 6'd1, 48'hFFFF_FFFF_FFFF);
        // Length above the maximum is clamped.
        send_item(KIND_LOAD, 8'h80, 6'd63, 48'hA5A5_5A5A_0F0F);
        send_item(KIND_LOAD, 8'h0F, 6'd0, 48'hFFFF_FFFF_FFFF);
        send_item(KIND_LOAD, 8'h7F, 6'd16, 48'h0000_0000_C3A5);
        send_item(KIND_LOAD, 8'h01, 6'd5, 48'h0000_0000_0000);
        send_byte(8'h00);
        send_flush();
        send_byte(8'hFF);
        send_flush();
        send_flush();
        // A full word on a boundary must not leave an extra word before the flush.
        send_byte(8'h7F);
        send_byte(8'h0F);
        send_flush();
        send_byte(8'h01);
        send_byte(8'h80);
        send_byte(8'hFF);
        send_flush();
        send_item(KIND_NONE, 8'hFF, 6'd63, 48'hFFFF_FFFF_FFFF);
        send_byte(8'hFF);
        send_item(KIND_NONE, 8'h00, 6'd0, 48'h0);
        send_flush();
    endtask

    task automatic test_random_stream(input int n_items);
        int               sent;
        int               pick;
        logic [LEN_W-1:0] len;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(99);
            if (pick < 12) begin
                len = ($urandom_range(9) == 0) ? LEN_W'($urandom_range(63))
                                               : LEN_W'($urandom_range(20, 1));
                send_item(KIND_LOAD, SYM_W'($urandom), len, {$urandom, $urandom});
                sent++;
            end else if (pick < 82) begin
                send_byte(loaded_syms[$urandom_range(loaded_syms.size() - 1)]);
                sent++;
            end else if (pick < 95) begin
                send_flush();
                sent++;
            end else begin
                // Unused kind: the block drops it.
                send_item(KIND_NONE, SYM_W'($urandom), LEN_W'($urandom), {$urandom, $urandom});
            end
        end
    endtask

    always @(posedge clk) begin
        t_word got;
        t_word want;
        if (rst_n && m_valid && m_ready) begin
            got = '{m_data, m_last, m_user[0]};
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected word %h last %b has_data %b",
                             got.word, got.last, got.has_data);
            end else begin
                want = expected_words.pop_front();
                if (got != want) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("word exp %h got %h, last exp %b got %b, has_data exp %b got %b",
                                 want.word, got.word, want.last, got.last,
                                 want.has_data, got.has_data);
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (RST_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_random_stream(63);
        // Hold off mid-stream until everything pending has come out.
        wait_drained();
        src_idle_pct  = 71;
        sink_idle_pct = 19;
        test_random_stream(63);
        wait_drained();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        test_random_stream(63);
        wait_drained();
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
